// ===== rtl/size_class_slot_allocator_core_assert.svh =====
// Assertion macros for the slot allocator core.
`ifndef SIZE_CLASS_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SCSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scsa assertion failed");
// next-cycle implication
`define SCSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scsa assertion failed");
`else
`define SCSA_ASSERT_NOW(label, clk, rst, ante, cons)
`define SCSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/scsa_pkg.sv =====
package scsa_pkg;

  localparam int CW    = 9;   // config register width
  localparam int REQW  = 16;  // request and handle size width
  localparam int OFFW  = 17;  // byte offset width on the ports
  localparam int SZW   = 9;   // slot size width
  localparam int ADW   = 18;  // internal offset width, holds 511 * 480
  localparam int NPOOL = 4;
  localparam int PW    = 2;   // pool select width
  localparam int CIW   = 3;   // config index width

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_RANGE     = 3'd4,
    ST_MISALIGN  = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam logic [SZW-1:0] CLASS_SIZE [NPOOL] = '{9'd32, 9'd64, 9'd128, 9'd256};
  localparam int CLASS_SHIFT [NPOOL] = '{5, 6, 7, 8};

endpackage

// ===== rtl/scsa_if.sv =====
interface scsa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [scsa_pkg::REQW-1:0]   req_size;
  logic [scsa_pkg::OFFW-1:0]   handle_offset;
  logic [scsa_pkg::REQW-1:0]   handle_size;

  modport source(output valid, func, req_size, handle_offset, handle_size, input ready);
  modport sink(input valid, func, req_size, handle_offset, handle_size, output ready);
endinterface

interface scsa_rsp_if;
  logic                        valid;
  logic                        ready;
  scsa_pkg::status_t           status;
  logic [scsa_pkg::OFFW-1:0]   slot_offset;
  logic [scsa_pkg::SZW-1:0]    slot_size;
  logic [scsa_pkg::OFFW-1:0]   high_water;

  modport source(output valid, status, slot_offset, slot_size, high_water, input ready);
  modport sink(input valid, status, slot_offset, slot_size, high_water, output ready);
endinterface

// ===== rtl/size_class_slot_allocator_core.sv =====
// Slot allocator over one byte region split into 32, 64, 128 and 256 byte pools.
// Channels: req carries one item (func, req_size, handle_offset, handle_size);
// rsp returns exactly one result item per request (status, slot_offset,
// slot_size, high_water). Both use valid/ready; an item moves when both are high.
// Configuration: cfg_we writes cfg_data into count register cfg_index (0..3);
// any such write re-initializes all free stacks and clears the high-water mark.
// Write only while the block is idle. Indexes above 3 are ignored.
// Flow: an accepted item moves to the execute state, and the result register
// loads as that state ends; the result can be taken from then on.
// Items do not overlap in the core. The free stacks live in one synchronous
// memory; the accept cycle issues the stack read, the execute cycle takes the
// read data and writes back the push, and the next item needs the new depth.
// Reset clears all counts, so every pool is empty; no clearing pass is run,
// since stack entries below the lowest depth reached since re-init are
// generated from the count instead of read from memory.
// A stalled rsp holds its result; req.ready stays low until the result register
// drains, at the latest in the same cycle as the next accept.
`include "size_class_slot_allocator_core_assert.svh"

module size_class_slot_allocator_core #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [scsa_pkg::CIW-1:0]    cfg_index,
  input  logic [scsa_pkg::CW-1:0]     cfg_data,
  scsa_req_if.sink                    req,
  scsa_rsp_if.source                  rsp
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;  // slot index width
  localparam int DW = $clog2(MAX_SLOTS + 1);                     // stack depth width
  localparam int AW = scsa_pkg::PW + IW;                         // stack memory address
  localparam int ADW = scsa_pkg::ADW;
  localparam int NPOOL = scsa_pkg::NPOOL;

  // configuration and per-pool bookkeeping
  logic [scsa_pkg::CW-1:0] count [NPOOL];
  logic [scsa_pkg::CW-1:0] csat [NPOOL];     // count saturated to MAX_SLOTS
  logic [scsa_pkg::CW-1:0] cnt_eff [NPOOL];  // counts after a pending write
  logic [DW-1:0]           depth [NPOOL];
  logic [DW-1:0]           low [NPOOL];      // lowest depth since re-init
  logic [ADW-1:0]          base [NPOOL+1];
  logic [ADW-1:0]          high_mark;
  logic                    cfg_hit;

  // control
  scsa_pkg::state_t state, state_next;
  logic             accept;

  // request held for the execute cycle
  logic                    op_free;
  logic [scsa_pkg::PW-1:0] op_pool;
  scsa_pkg::status_t       op_status;
  logic [IW-1:0]           op_pos;     // push position
  logic [IW-1:0]           op_push;    // slot index to push
  logic [IW-1:0]           op_orig;    // untouched entry value for a pop
  logic                    op_bypass;
  logic [DW-1:0]           op_dnew;

  // stack memory
  logic [IW-1:0] mem [1 << AW];
  logic [IW-1:0] rd_data;
  logic          wr_en;

  // result register
  logic                        rsp_valid_q;
  scsa_pkg::status_t           rsp_status_q;
  logic [scsa_pkg::OFFW-1:0]   rsp_off_q;
  logic [scsa_pkg::SZW-1:0]    rsp_size_q;
  logic [scsa_pkg::OFFW-1:0]   rsp_hw_q;

  // accept-cycle decode
  logic [scsa_pkg::PW-1:0] a_pool, f_pool, sel_pool;
  logic                    a_big, f_bad;
  logic [DW-1:0]           dep, dm1, lowv;
  logic [ADW-1:0]          hoff, rel;
  logic                    in_range, misal, full;
  scsa_pkg::status_t       dec_status;

  // execute-cycle math
  logic [IW-1:0]  pop_idx;
  logic [ADW-1:0] ex_off, ex_end, hw_next;
  logic           ex_alloc_ok, ex_free_ok;

  assign cfg_hit = cfg_we && (cfg_index < scsa_pkg::CIW'(NPOOL));

  always_comb begin
    for (int k = 0; k < NPOOL; k++) begin
      csat[k] = (32'(count[k]) > MAX_SLOTS) ? scsa_pkg::CW'(MAX_SLOTS) : count[k];
      cnt_eff[k] = (cfg_hit && (cfg_index[scsa_pkg::PW-1:0] == scsa_pkg::PW'(k))) ?
                   cfg_data : count[k];
    end
    // pools sit back to back; base[NPOOL] is the end of the region
    base[0] = '0;
    for (int k = 0; k < NPOOL; k++) begin
      base[k+1] = base[k] + (ADW'(csat[k]) << scsa_pkg::CLASS_SHIFT[k]);
    end
  end

  // pick the pool: smallest class that fits for allocate, exact class for free
  always_comb begin
    a_big = 1'b0;
    if (req.req_size <= scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[0])) a_pool = 2'd0;
    else if (req.req_size <= scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[1])) a_pool = 2'd1;
    else if (req.req_size <= scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[2])) a_pool = 2'd2;
    else if (req.req_size <= scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[3])) a_pool = 2'd3;
    else begin
      a_pool = 2'd3;
      a_big  = 1'b1;
    end

    f_bad = 1'b0;
    if (req.handle_size == scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[0])) f_pool = 2'd0;
    else if (req.handle_size == scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[1])) f_pool = 2'd1;
    else if (req.handle_size == scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[2])) f_pool = 2'd2;
    else if (req.handle_size == scsa_pkg::REQW'(scsa_pkg::CLASS_SIZE[3])) f_pool = 2'd3;
    else begin
      f_pool = 2'd0;
      f_bad  = 1'b1;
    end
  end

  always_comb begin
    sel_pool = (req.func == scsa_pkg::FN_FREE) ? f_pool : a_pool;
    dep      = depth[sel_pool];
    lowv     = low[sel_pool];
    dm1      = dep - DW'(1);

    hoff     = ADW'(req.handle_offset);
    rel      = hoff - base[{1'b0, f_pool}];
    in_range = (hoff >= base[{1'b0, f_pool}]) && (hoff < base[{1'b0, f_pool} + 3'd1]);
    misal    = (rel & ADW'(scsa_pkg::CLASS_SIZE[f_pool] - 9'd1)) != '0;
    full     = dep >= DW'(MAX_SLOTS);

    if (req.func == scsa_pkg::FN_ALLOC) begin
      if (a_big) dec_status = scsa_pkg::ST_TOO_LARGE;
      else if (dep == '0) dec_status = scsa_pkg::ST_EXHAUSTED;
      else dec_status = scsa_pkg::ST_OK;
    end else begin
      if (f_bad) dec_status = scsa_pkg::ST_BAD_SIZE;
      else if (!in_range) dec_status = scsa_pkg::ST_RANGE;
      else if (misal) dec_status = scsa_pkg::ST_MISALIGN;
      else if (full) dec_status = scsa_pkg::ST_FULL;
      else dec_status = scsa_pkg::ST_OK;
    end
  end

  // state machine: accept in idle, finish in execute
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      scsa_pkg::S_IDLE: begin
        req.ready = !rsp_valid_q || rsp.ready;
        if (req.valid && req.ready) state_next = scsa_pkg::S_EXEC;
      end
      scsa_pkg::S_EXEC: begin
        state_next = scsa_pkg::S_IDLE;
      end
      default: begin
        state_next = scsa_pkg::S_IDLE;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  // latch the decoded request
  always_ff @(posedge clk) begin
    if (accept) begin
      op_free   <= (req.func == scsa_pkg::FN_FREE);
      op_pool   <= sel_pool;
      op_status <= dec_status;
      op_pos    <= IW'(dep);
      op_push   <= IW'(rel >> scsa_pkg::CLASS_SHIFT[f_pool]);
      op_orig   <= IW'(DW'(csat[sel_pool]) - DW'(1) - dm1);
      op_bypass <= dm1 < lowv;
      op_dnew   <= (req.func == scsa_pkg::FN_FREE) ? dep + DW'(1) : dm1;
    end
  end

  // stack memory: read on accept, push on execute
  assign wr_en = (state == scsa_pkg::S_EXEC) && op_free && (op_status == scsa_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (accept) rd_data <= mem[{sel_pool, IW'(dm1)}];
    if (wr_en) mem[{op_pool, op_pos}] <= op_push;
  end

  always_comb begin
    ex_alloc_ok = (state == scsa_pkg::S_EXEC) && !op_free && (op_status == scsa_pkg::ST_OK);
    ex_free_ok  = wr_en;
    // entries below the lowest depth were never overwritten since re-init
    pop_idx = op_bypass ? op_orig : rd_data;
    ex_off  = base[{1'b0, op_pool}] + (ADW'(pop_idx) << scsa_pkg::CLASS_SHIFT[op_pool]);
    ex_end  = ex_off + ADW'(scsa_pkg::CLASS_SIZE[op_pool]);
    hw_next = (ex_alloc_ok && (ex_end > high_mark)) ? ex_end : high_mark;
  end

  // counts, depths, low marks and high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NPOOL; k++) begin
        count[k] <= '0;
        depth[k] <= '0;
        low[k]   <= '0;
      end
      high_mark <= '0;
    end else if (cfg_hit) begin
      for (int k = 0; k < NPOOL; k++) begin
        count[k] <= cnt_eff[k];
        depth[k] <= (32'(cnt_eff[k]) > MAX_SLOTS) ? DW'(MAX_SLOTS) : DW'(cnt_eff[k]);
        low[k]   <= (32'(cnt_eff[k]) > MAX_SLOTS) ? DW'(MAX_SLOTS) : DW'(cnt_eff[k]);
      end
      high_mark <= '0;
    end else begin
      if (ex_alloc_ok || ex_free_ok) depth[op_pool] <= op_dnew;
      if (ex_alloc_ok && op_bypass) low[op_pool] <= op_dnew;
      high_mark <= hw_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (state == scsa_pkg::S_EXEC) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == scsa_pkg::S_EXEC) begin
      rsp_status_q <= op_status;
      rsp_off_q    <= ex_alloc_ok ? ex_off[scsa_pkg::OFFW-1:0] : '0;
      rsp_size_q   <= ex_alloc_ok ? scsa_pkg::CLASS_SIZE[op_pool] : '0;
      rsp_hw_q     <= hw_next[scsa_pkg::OFFW-1:0];
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.slot_offset = rsp_off_q;
  assign rsp.slot_size   = rsp_size_q;
  assign rsp.high_water  = rsp_hw_q;

  // the result register is always free when an item finishes
  `SCSA_ASSERT_NOW(a_slot_free, clk, rst, state == scsa_pkg::S_EXEC, !rsp_valid_q)
  // an accepted item finishes in the following cycle
  `SCSA_ASSERT_NEXT(a_exec_follows, clk, rst, accept, state == scsa_pkg::S_EXEC)
  // a result appears right after execute
  `SCSA_ASSERT_NEXT(a_rsp_after_exec, clk, rst, state == scsa_pkg::S_EXEC, rsp_valid_q)

  for (genvar g = 0; g < NPOOL; g++) begin : g_chk
    // untouched region never exceeds the live stack
    `SCSA_ASSERT_NOW(a_low_le_depth, clk, rst, 1'b1, (low[g] <= depth[g]) && (depth[g] <= DW'(MAX_SLOTS)))
  end

endmodule
